>>> rtl/igm_pkg.sv
package igm_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_HEIGHT_DEF   = 4096;
    localparam int CORDIC_STEPS_DEF = 14;

    localparam int FRAC_BITS = 4;
    localparam int ANG_SHIFT = 24;
    localparam int ATAN_LEN  = 24;

    // Field widths
    localparam int PIX_W   = 8;
    localparam int GRAD_W  = PIX_W + 1;
    localparam int MAG_W   = 13;
    localparam int ANG_W   = 12;
    localparam int CFG_W   = 13;
    localparam int WREG_W  = 11;
    localparam int HREG_W  = 13;
    localparam int IDX_W   = 2;

    // Sum of squares with fraction bits, kept even for the root
    localparam int SQ_W       = 26;
    localparam int SQRT_STEPS = SQ_W / 2;

    localparam logic [IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_PAD    = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // round(atan(2^-i) in degrees * 2^24)
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115
    };

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CALC,
        S_OUT
    } t_ctl_state;

    typedef enum logic [1:0] {
        C_IDLE,
        C_SQUARE,
        C_ITER,
        C_DONE
    } t_calc_phase;

endpackage

>>> rtl/igm_line_mem.sv
module igm_line_mem #(
    parameter int MAX_WIDTH = igm_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_rd_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_rd_addr_nxt,
    output logic [igm_pkg::PIX_W-1:0]     o_center,
    output logic [igm_pkg::PIX_W-1:0]     o_right,
    output logic [igm_pkg::PIX_W-1:0]     o_above,
    input  logic                          i_cur_we,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_cur_addr,
    input  logic [igm_pkg::PIX_W-1:0]     i_cur_data,
    input  logic                          i_abv_we,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_abv_addr,
    input  logic [igm_pkg::PIX_W-1:0]     i_abv_data
);

    logic [igm_pkg::PIX_W-1:0] r_row_cur [MAX_WIDTH];
    logic [igm_pkg::PIX_W-1:0] r_row_abv [MAX_WIDTH];

    always_ff @(posedge i_clk) begin
        if (i_cur_we) begin
            r_row_cur[i_cur_addr] <= i_cur_data;
        end
        o_center <= r_row_cur[i_rd_addr];
        o_right  <= r_row_cur[i_rd_addr_nxt];
    end

    always_ff @(posedge i_clk) begin
        if (i_abv_we) begin
            r_row_abv[i_abv_addr] <= i_abv_data;
        end
        o_above <= r_row_abv[i_rd_addr];
    end

endmodule

>>> rtl/igm_calc.sv
module igm_calc #(
    parameter int CORDIC_STEPS = igm_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [igm_pkg::GRAD_W-1:0] i_gx,
    input  logic signed [igm_pkg::GRAD_W-1:0] i_gy,
    output logic                              o_done,
    output logic [igm_pkg::MAG_W-1:0]         o_magnitude,
    output logic [igm_pkg::ANG_W-1:0]         o_angle
);

    localparam int N_STEPS = (CORDIC_STEPS > igm_pkg::SQRT_STEPS) ?
                             CORDIC_STEPS : igm_pkg::SQRT_STEPS;
    localparam int CNT_W   = $clog2(N_STEPS + 1);
    localparam int XY_W    = 36;
    localparam int Z_W     = 34;
    localparam int SQ_W    = igm_pkg::SQ_W;
    localparam int PROD_W  = 2 * igm_pkg::GRAD_W;
    localparam int RND_SH  = igm_pkg::ANG_SHIFT - igm_pkg::FRAC_BITS;
    localparam logic [Z_W-1:0] Z_90  = Z_W'(90)  << igm_pkg::ANG_SHIFT;
    localparam logic [Z_W-1:0] Z_180 = Z_W'(180) << igm_pkg::ANG_SHIFT;
    localparam logic [Z_W-1:0] Z_HALF = Z_W'(1) << (RND_SH - 1);

    igm_pkg::t_calc_phase r_phase, n_phase;

    logic [igm_pkg::PIX_W-1:0] r_a, r_b;
    logic                      r_neg;
    logic [PROD_W-1:0]         r_sq_a, r_sq_b;
    logic [CNT_W-1:0]          r_cnt;
    logic [SQ_W-1:0]           r_v, r_r, r_bit;
    logic signed [XY_W-1:0]    r_x, r_y;
    logic signed [Z_W-1:0]     r_z;

    logic [SQ_W-1:0]        sum_sq, rb;
    logic signed [XY_W-1:0] xs, ys;
    logic [4:0]             tab_idx;
    logic signed [Z_W-1:0]  tab_val, z_clamp;
    logic [Z_W-1:0]         t_ang, o_ang_full;
    logic [SQ_W-1:0]        mag_full;

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            igm_pkg::C_IDLE:   if (i_start) n_phase = igm_pkg::C_SQUARE;
            igm_pkg::C_SQUARE: n_phase = igm_pkg::C_ITER;
            igm_pkg::C_ITER:   if (r_cnt == CNT_W'(N_STEPS - 1)) n_phase = igm_pkg::C_DONE;
            igm_pkg::C_DONE:   n_phase = igm_pkg::C_IDLE;
            default:           n_phase = igm_pkg::C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= igm_pkg::C_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    assign sum_sq  = (SQ_W'(r_sq_a) + SQ_W'(r_sq_b)) << (2 * igm_pkg::FRAC_BITS);
    assign rb      = r_r + r_bit;
    assign xs      = r_x >>> r_cnt;
    assign ys      = r_y >>> r_cnt;
    assign tab_idx = 5'(r_cnt);
    assign tab_val = Z_W'(igm_pkg::ATAN_TAB[tab_idx]);

    always_ff @(posedge i_clk) begin
        case (r_phase)
            igm_pkg::C_IDLE: begin
                // operands held until the next start so the result stays put
                if (i_start) begin
                    r_a   <= i_gx[igm_pkg::GRAD_W-1] ? igm_pkg::PIX_W'(-i_gx)
                                                      : igm_pkg::PIX_W'(i_gx);
                    r_b   <= i_gy[igm_pkg::GRAD_W-1] ? igm_pkg::PIX_W'(-i_gy)
                                                      : igm_pkg::PIX_W'(i_gy);
                    r_neg <= i_gx[igm_pkg::GRAD_W-1];
                end
            end
            igm_pkg::C_SQUARE: begin
                r_sq_a <= PROD_W'(r_a) * PROD_W'(r_a);
                r_sq_b <= PROD_W'(r_b) * PROD_W'(r_b);
                r_x    <= XY_W'(r_a) << igm_pkg::ANG_SHIFT;
                r_y    <= XY_W'(r_b) << igm_pkg::ANG_SHIFT;
                r_cnt  <= '0;
                r_bit  <= SQ_W'(1) << (SQ_W - 2);
                r_r    <= '0;
                if (r_b == '0) begin
                    r_z <= '0;
                end else if (r_a == '0) begin
                    r_z <= Z_90;
                end else begin
                    r_z <= '0;
                end
            end
            igm_pkg::C_ITER: begin
                r_cnt <= r_cnt + 1'b1;
                // first step loads the sum of squares
                if (r_cnt == '0) begin
                    if (sum_sq >= r_bit) begin
                        r_v <= sum_sq - r_bit;
                        r_r <= r_bit;
                    end else begin
                        r_v <= sum_sq;
                        r_r <= '0;
                    end
                    r_bit <= r_bit >> 2;
                end else if (r_cnt < CNT_W'(igm_pkg::SQRT_STEPS)) begin
                    if (r_v >= rb) begin
                        r_v <= r_v - rb;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                if (r_cnt < CNT_W'(CORDIC_STEPS) && r_a != '0 && r_b != '0) begin
                    if (r_y >= 0) begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + tab_val;
                    end else begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - tab_val;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (r_z < 0) begin
            z_clamp = '0;
        end else if (r_z > $signed(Z_90)) begin
            z_clamp = $signed(Z_90);
        end else begin
            z_clamp = r_z;
        end
        t_ang      = r_neg ? (Z_180 - Z_W'(z_clamp)) : Z_W'(z_clamp);
        o_ang_full = (t_ang + Z_HALF) >> RND_SH;
        mag_full   = (r_v > r_r) ? r_r + 1'b1 : r_r;
    end

    assign o_done      = (r_phase == igm_pkg::C_DONE);
    assign o_angle     = (o_ang_full > Z_W'({igm_pkg::ANG_W{1'b1}})) ?
                         {igm_pkg::ANG_W{1'b1}} : igm_pkg::ANG_W'(o_ang_full);
    assign o_magnitude = (mag_full > SQ_W'({igm_pkg::MAG_W{1'b1}})) ?
                         {igm_pkg::MAG_W{1'b1}} : igm_pkg::MAG_W'(mag_full);

endmodule

>>> rtl/image_gradient_magnitude_angle_unit.sv
// Central-difference gradient over an 8-bit gray image fed in raster order.
// Each pixel beat (tuser = 0) is the next pixel; its result is the magnitude
// and unsigned angle (0..180 deg) of the pixel directly above, both with 4
// fraction bits, so the first row gives no result. After the last row, one
// flush beat (tuser = 1) per column drains it; tlast marks the final result.
// An item with a result passes through these steps: the accept, a line-buffer
// read, the squares, the shared root/CORDIC iterations, the done step and the
// output load, which waits while the result register is full and tready is low;
// items that give no result go back to idle after the read. After reset the
// line buffers are zeroed before the first beat is taken; configuration writes
// are taken at any time and belong in idle periods.
module image_gradient_magnitude_angle_unit #(
    parameter int MAX_WIDTH    = igm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = igm_pkg::MAX_HEIGHT_DEF,
    parameter int CORDIC_STEPS = igm_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [7:0] pixel
    input  logic [0:0]                    i_s_tuser,   // [0] op: 0 pixel, 1 flush
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [31:0]                   o_m_tdata,   // [12:0] magnitude, [24:13] angle_deg
    output logic                          o_m_tlast,   // final pixel of image
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [igm_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [igm_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = igm_pkg::PIX_W;
    localparam int GW = igm_pkg::GRAD_W;

    igm_pkg::t_ctl_state r_state, n_state;

    // configuration
    logic [igm_pkg::WREG_W-1:0] r_width;
    logic [igm_pkg::HREG_W-1:0] r_height;
    logic                       r_pad_mode;

    // position and item state
    logic [AW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          r_drain, n_drain;
    logic [PW-1:0] r_left, n_left;
    logic [AW-1:0] r_clr_addr;
    logic          r_op;
    logic [PW-1:0] r_px;

    // output register
    logic                       r_out_valid;
    logic [igm_pkg::MAG_W-1:0]  r_out_mag;
    logic [igm_pkg::ANG_W-1:0]  r_out_ang;
    logic                       r_out_last, r_last, n_last;

    // line buffer ports
    logic [PW-1:0] center, right_raw, above;
    logic          cur_we, abv_we;
    logic [AW-1:0] wr_addr;
    logic [PW-1:0] cur_data;

    // gradient
    logic            calc_start, calc_done;
    logic signed [GW-1:0] gx, gy;
    logic [igm_pkg::MAG_W-1:0] calc_mag;
    logic [igm_pkg::ANG_W-1:0] calc_ang;

    logic [WW-1:0] w_eff, col_nxt;
    logic [HW-1:0] h_eff, row_nxt;
    logic          row_end, img_end;
    logic [PW-1:0] pad, lf, rt, up, dn;
    logic          s_accept, out_load;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == igm_pkg::S_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign out_load    = (r_state == igm_pkg::S_OUT) && (!r_out_valid || i_m_tready);

    // effective sizes: 0 acts as 1, oversize clamps to MAX_WIDTH and MAX_HEIGHT
    always_comb begin
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_height);
        end
        col_nxt = WW'(r_col) + 1'b1;
        row_nxt = HW'(r_row) + 1'b1;
        row_end = !(col_nxt < w_eff);
        img_end = (row_nxt >= h_eff);
    end

    // neighbors of the pixel being reported
    always_comb begin
        pad = r_pad_mode ? center : '0;
        lf  = (r_col == '0) ? pad : r_left;
        rt  = row_end ? pad : right_raw;
        if (r_drain) begin
            up = (r_row == '0) ? pad : above;
            dn = pad;
        end else begin
            up = (r_row == RW'(1)) ? pad : above;
            dn = r_px;
        end
        gx = $signed({1'b0, rt}) - $signed({1'b0, lf});
        gy = $signed({1'b0, dn}) - $signed({1'b0, up});
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            igm_pkg::S_CLEAR: begin
                if (r_clr_addr == AW'(MAX_WIDTH - 1)) n_state = igm_pkg::S_IDLE;
            end
            igm_pkg::S_IDLE: begin
                if (s_accept) n_state = igm_pkg::S_READ;
            end
            igm_pkg::S_READ: begin
                if (r_drain) begin
                    n_state = (r_op == igm_pkg::OP_FLUSH) ? igm_pkg::S_CALC
                                                          : igm_pkg::S_IDLE;
                end else if (r_op == igm_pkg::OP_PIXEL && r_row != '0) begin
                    n_state = igm_pkg::S_CALC;
                end else begin
                    n_state = igm_pkg::S_IDLE;
                end
            end
            igm_pkg::S_CALC: begin
                if (calc_done) n_state = igm_pkg::S_OUT;
            end
            igm_pkg::S_OUT: begin
                if (out_load) n_state = igm_pkg::S_IDLE;
            end
            default: n_state = igm_pkg::S_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_drain    = r_drain;
        n_left     = r_left;
        n_last     = r_last;
        cur_we     = 1'b0;
        abv_we     = 1'b0;
        wr_addr    = r_col;
        cur_data   = r_px;
        calc_start = 1'b0;
        case (r_state)
            igm_pkg::S_CLEAR: begin
                cur_we   = 1'b1;
                abv_we   = 1'b1;
                wr_addr  = r_clr_addr;
                cur_data = '0;
            end
            igm_pkg::S_READ: begin
                if (!r_drain && r_op == igm_pkg::OP_PIXEL) begin
                    cur_we = 1'b1;
                    if (r_row != '0) begin
                        abv_we     = 1'b1;
                        n_left     = center;
                        calc_start = 1'b1;
                        n_last     = 1'b0;
                    end
                    if (row_end) begin
                        n_col = '0;
                        if (img_end) begin
                            n_drain = 1'b1;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end else begin
                        n_col = AW'(col_nxt);
                    end
                end else if (r_drain && r_op == igm_pkg::OP_FLUSH) begin
                    n_left     = center;
                    calc_start = 1'b1;
                    n_last     = row_end;
                    if (row_end) begin
                        n_col   = '0;
                        n_row   = '0;
                        n_drain = 1'b0;
                    end else begin
                        n_col = AW'(col_nxt);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= igm_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_drain     <= 1'b0;
            r_left      <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            r_width     <= igm_pkg::WREG_W'(640);
            r_height    <= igm_pkg::HREG_W'(480);
            r_pad_mode  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_drain <= n_drain;
            r_left  <= n_left;
            r_last  <= n_last;
            if (r_state == igm_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    igm_pkg::CFG_WIDTH:  r_width    <= i_cfg_data[igm_pkg::WREG_W-1:0];
                    igm_pkg::CFG_HEIGHT: r_height   <= i_cfg_data[igm_pkg::HREG_W-1:0];
                    igm_pkg::CFG_PAD:    r_pad_mode <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // beat capture and result registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op <= i_s_tuser[0];
            r_px <= i_s_tdata;
        end
        if (out_load) begin
            r_out_mag  <= calc_mag;
            r_out_ang  <= calc_ang;
            r_out_last <= r_last;
        end
    end

    igm_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk         (i_clk),
        .i_rd_addr     (r_col),
        .i_rd_addr_nxt (AW'(col_nxt)),
        .o_center      (center),
        .o_right       (right_raw),
        .o_above       (above),
        .i_cur_we      (cur_we),
        .i_cur_addr    (wr_addr),
        .i_cur_data    (cur_data),
        .i_abv_we      (abv_we),
        .i_abv_addr    (wr_addr),
        .i_abv_data    ((r_state == igm_pkg::S_CLEAR) ? '0 : center)
    );

    igm_calc #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (calc_start),
        .i_gx        (gx),
        .i_gy        (gy),
        .o_done      (calc_done),
        .o_magnitude (calc_mag),
        .o_angle     (calc_ang)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_ang, r_out_mag};
    assign o_m_tlast  = r_out_last;

endmodule
